/* design/nectx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nectx_pkg;

    // Width of the configuration registers and of the frame code field.
    localparam int CFG_W        = 16;
    localparam int FRAME_CODE_W = 32;
    localparam int CFG_IDX_W    = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPACE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_GAP    = 3'd6;

    // Reset values of the configuration registers, in microsecond ticks.
    localparam logic [CFG_W-1:0] RST_LEADER_MARK  = 16'd9000;
    localparam logic [CFG_W-1:0] RST_LEADER_SPACE = 16'd4500;
    localparam logic [CFG_W-1:0] RST_BIT_MARK     = 16'd560;
    localparam logic [CFG_W-1:0] RST_ONE_SPACE    = 16'd1690;
    localparam logic [CFG_W-1:0] RST_ZERO_SPACE   = 16'd560;
    localparam logic [CFG_W-1:0] RST_REPEAT_SPACE = 16'd2250;
    localparam logic [CFG_W-1:0] RST_GUARD_GAP    = 16'd40000;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_SEND_FRAME  = 2'd1,
        OP_SEND_REPEAT = 2'd2,
        OP_NONE        = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4,
        PH_STOP_MARK  = 3'd5,
        PH_GAP        = 3'd6
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] leader_mark;
        logic [CFG_W-1:0] leader_space;
        logic [CFG_W-1:0] bit_mark;
        logic [CFG_W-1:0] one_space;
        logic [CFG_W-1:0] zero_space;
        logic [CFG_W-1:0] repeat_space;
        logic [CFG_W-1:0] guard_gap;
    } t_cfg;

    typedef struct packed {
        logic mark_active;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } t_result;

endpackage

`default_nettype wire

/* design/nectx_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module nectx_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_wr_en,
    input  wire logic [nectx_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  wire logic [nectx_pkg::CFG_W-1:0]        i_wr_data,
    output nectx_pkg::t_cfg                         o_cfg
);

    nectx_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_mark  <= nectx_pkg::RST_LEADER_MARK;
            r_cfg.leader_space <= nectx_pkg::RST_LEADER_SPACE;
            r_cfg.bit_mark     <= nectx_pkg::RST_BIT_MARK;
            r_cfg.one_space    <= nectx_pkg::RST_ONE_SPACE;
            r_cfg.zero_space   <= nectx_pkg::RST_ZERO_SPACE;
            r_cfg.repeat_space <= nectx_pkg::RST_REPEAT_SPACE;
            r_cfg.guard_gap    <= nectx_pkg::RST_GUARD_GAP;
        end else if (i_wr_en) begin
            case (i_wr_index)
                nectx_pkg::CFG_LEADER_MARK:  r_cfg.leader_mark  <= i_wr_data;
                nectx_pkg::CFG_LEADER_SPACE: r_cfg.leader_space <= i_wr_data;
                nectx_pkg::CFG_BIT_MARK:     r_cfg.bit_mark     <= i_wr_data;
                nectx_pkg::CFG_ONE_SPACE:    r_cfg.one_space    <= i_wr_data;
                nectx_pkg::CFG_ZERO_SPACE:   r_cfg.zero_space   <= i_wr_data;
                nectx_pkg::CFG_REPEAT_SPACE: r_cfg.repeat_space <= i_wr_data;
                nectx_pkg::CFG_GUARD_GAP:    r_cfg.guard_gap    <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/nectx_phase_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module nectx_phase_engine #(
    parameter int CODE_BITS  = 32,
    parameter int TICK_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire nectx_pkg::t_opcode     i_opcode,
    input  wire logic [CODE_BITS-1:0]   i_code,
    input  wire nectx_pkg::t_cfg        i_cfg,
    output nectx_pkg::t_result          o_res
);

    localparam int CW = $clog2(CODE_BITS + 1);
    localparam int LW = (TICK_WIDTH > nectx_pkg::CFG_W) ? TICK_WIDTH : nectx_pkg::CFG_W;
    localparam logic [LW-1:0] TICK_MAX_L = LW'((64'd1 << TICK_WIDTH) - 64'd1);

    // Zero counts as one tick; values beyond the counter saturate.
    function automatic logic [TICK_WIDTH-1:0] f_load_len(input logic [nectx_pkg::CFG_W-1:0] v);
        logic [LW-1:0] w;
        begin
            w = LW'(v);
            if (w == '0) w = LW'(1);
            if (w > TICK_MAX_L) w = TICK_MAX_L;
            return w[TICK_WIDTH-1:0];
        end
    endfunction

    nectx_pkg::t_phase       r_phase, n_phase;
    logic                    r_repeat, n_repeat;
    logic [CW-1:0]           r_bits, n_bits;
    logic [TICK_WIDTH-1:0]   r_ticks, n_ticks;
    logic [CODE_BITS-1:0]    r_code, n_code;

    logic                    is_cmd;
    logic                    is_idle;
    logic                    tick_run;
    logic [TICK_WIDTH-1:0]   ticks_dec;
    logic                    expired;
    logic [CW-1:0]           bits_inc;

    assign is_cmd    = (i_opcode == nectx_pkg::OP_SEND_FRAME) ||
                       (i_opcode == nectx_pkg::OP_SEND_REPEAT);
    assign is_idle   = (r_phase == nectx_pkg::PH_IDLE);
    assign tick_run  = i_en && (i_opcode == nectx_pkg::OP_TICK) && !is_idle;
    assign ticks_dec = r_ticks - TICK_WIDTH'(1);
    assign expired   = (ticks_dec == '0);
    assign bits_inc  = r_bits + CW'(1);

    // Next state.
    always_comb begin
        n_phase  = r_phase;
        n_repeat = r_repeat;
        n_bits   = r_bits;
        n_ticks  = r_ticks;
        n_code   = r_code;
        if (i_en && is_cmd && is_idle) begin
            n_repeat = (i_opcode == nectx_pkg::OP_SEND_REPEAT);
            n_code   = (i_opcode == nectx_pkg::OP_SEND_FRAME) ? i_code : '0;
            n_bits   = '0;
            n_phase  = nectx_pkg::PH_LEAD_MARK;
            n_ticks  = f_load_len(i_cfg.leader_mark);
        end else if (tick_run) begin
            n_ticks = ticks_dec;
            if (expired) begin
                case (r_phase)
                    nectx_pkg::PH_LEAD_MARK: begin
                        n_phase = nectx_pkg::PH_LEAD_SPACE;
                        n_ticks = f_load_len(r_repeat ? i_cfg.repeat_space
                                                      : i_cfg.leader_space);
                    end
                    nectx_pkg::PH_LEAD_SPACE: begin
                        n_phase = r_repeat ? nectx_pkg::PH_STOP_MARK
                                           : nectx_pkg::PH_BIT_MARK;
                        n_bits  = '0;
                        n_ticks = f_load_len(i_cfg.bit_mark);
                    end
                    nectx_pkg::PH_BIT_MARK: begin
                        n_phase = nectx_pkg::PH_BIT_SPACE;
                        n_ticks = f_load_len(r_code[0] ? i_cfg.one_space
                                                       : i_cfg.zero_space);
                    end
                    nectx_pkg::PH_BIT_SPACE: begin
                        n_code  = r_code >> 1;
                        n_bits  = bits_inc;
                        n_phase = (bits_inc >= CW'(CODE_BITS)) ? nectx_pkg::PH_STOP_MARK
                                                               : nectx_pkg::PH_BIT_MARK;
                        n_ticks = f_load_len(i_cfg.bit_mark);
                    end
                    nectx_pkg::PH_STOP_MARK: begin
                        n_phase = nectx_pkg::PH_GAP;
                        n_ticks = f_load_len(i_cfg.guard_gap);
                    end
                    default: begin
                        n_phase = nectx_pkg::PH_IDLE;
                        n_ticks = '0;
                    end
                endcase
            end
        end
    end

    // Result for the item being processed.
    always_comb begin
        o_res.mark_active = tick_run && (r_phase inside {nectx_pkg::PH_LEAD_MARK,
                                                         nectx_pkg::PH_BIT_MARK,
                                                         nectx_pkg::PH_STOP_MARK});
        o_res.busy_res    = (n_phase != nectx_pkg::PH_IDLE);
        o_res.frame_done  = tick_run && expired && (r_phase == nectx_pkg::PH_GAP);
        o_res.rejected    = i_en && is_cmd && !is_idle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= nectx_pkg::PH_IDLE;
            r_repeat <= 1'b0;
            r_bits   <= '0;
            r_ticks  <= '0;
            r_code   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_repeat <= n_repeat;
            r_bits   <= n_bits;
            r_ticks  <= n_ticks;
            r_code   <= n_code;
        end
    end

endmodule

`default_nettype wire

/* design/nec_ir_frame_transmitter_top.sv */
// NEC infrared frame envelope generator.
// Input channel (i_in_valid / o_in_ready): each item carries an opcode and a
// 32-bit code. A tick item advances the frame by one microsecond; a send-frame
// or send-repeat item starts a frame when the block is idle and is rejected
// when a frame or its guard gap is still running.
// Output channel (o_out_valid / i_out_ready): exactly one result item per
// input item, in order: mark gate, busy flag, frame-done pulse, reject flag.
// Configuration channel (i_cfg_valid / o_cfg_ready): seven tick-count
// registers, always ready; write them only while no item is in flight.
// Data path: an accepted item sits in the input register, is then processed
// by the phase counter logic and lands in the result register. One item per
// cycle is sustained while the receiver takes results; the phase update is
// the only work per item. When the receiver stalls, the result register
// holds and the input register fills; o_in_ready then drops until the
// result is taken.
// A synchronous active-low reset returns the block to idle, empties both
// registers and restores the default NEC timings.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_transmitter_top #(
    parameter int CODE_BITS  = 32,
    parameter int TICK_WIDTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [1:0]                             i_opcode,
    input  wire logic [nectx_pkg::FRAME_CODE_W-1:0]     i_frame_code,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic                                        o_mark_active,
    output logic                                        o_busy_res,
    output logic                                        o_frame_done,
    output logic                                        o_rejected,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [nectx_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [nectx_pkg::CFG_W-1:0]            i_cfg_data
);

    // Input register.
    logic                   r_in_valid;
    nectx_pkg::t_opcode     r_in_opcode;
    logic [CODE_BITS-1:0]   r_in_code;

    // Result register.
    logic                   r_out_valid;
    nectx_pkg::t_result     r_out;

    logic                   advance;
    nectx_pkg::t_cfg        cfg;
    nectx_pkg::t_result     res;

    // The item in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    nectx_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    nectx_phase_engine #(
        .CODE_BITS  (CODE_BITS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_phase_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_opcode (r_in_opcode),
        .i_code   (r_in_code),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_opcode <= nectx_pkg::t_opcode'(i_opcode);
            r_in_code   <= i_frame_code[CODE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mark_active = r_out.mark_active;
    assign o_busy_res    = r_out.busy_res;
    assign o_frame_done  = r_out.frame_done;
    assign o_rejected    = r_out.rejected;

`ifndef SYNTHESIS
    // A command is never both rejected and the end of a guard gap.
    a_done_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_rejected && o_frame_done))
        else $error("frame_done and rejected set in one result");

    // The end of the guard gap leaves the block idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> !o_busy_res)
        else $error("busy after frame_done");

    // A mark tick is always followed by another phase of the frame.
    a_mark_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mark_active) |-> o_busy_res)
        else $error("mark tick reported while idle");

    // The input side stalls only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");
`endif

endmodule

`default_nettype wire
